// File: rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared definitions for the keyed slot table
// Table geometry, command and status codes, the sequencer states and the
// structures that pass between the controller and the slot store.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int KEY_BITS    = 64;
  localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int VALUE_BITS  = 32;
  localparam int INDEX_BITS  = 4;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_NFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Write request from the controller to the store.
  typedef struct packed {
    logic   data_en;
    logic   busy_set;
    logic   busy_clr;
    slot_t  idx;
    key_t   key;
    value_t value;
  } kst_wr_t;

  // Registered read response from the store.
  typedef struct packed {
    logic   busy;
    key_t   key;
    value_t value;
  } kst_rd_t;

endpackage

// File: rtl/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table: associative table with a linear scan
// A transaction is taken only while the block is idle: busy stays high from
// the accepting edge until done rises, and a new transaction may start in
// the cycle in which done is high. The single key comparator visits one slot
// per cycle behind the registered read port of the slot store; a drain step,
// a decide step and the registered result follow the scan.
// Reset: synchronous; every slot becomes free and the sequencer goes idle.
// The result is presented for one cycle with done high and cannot be stalled.
// ----------------------------------------------------------------------------
module keyed_slot_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [63:0]        lookup_key,
  input  logic signed [31:0] new_value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] found_value,
  output logic [3:0]         slot_index
);

  // Sequencer state. The scan issues one read per cycle; the comparison for
  // a slot happens in the following cycle, once its read data has been registered.
  kst_pkg::state_t state, state_next;

  // Transaction registers, captured when the transaction is accepted.
  kst_pkg::cmd_t   cmd;
  kst_pkg::key_t   key;
  kst_pkg::value_t value;

  // Scan counter and the compare-stage tag, a registered copy of it.
  kst_pkg::slot_t  scan_idx;
  kst_pkg::slot_t  cmp_idx;
  logic            cmp_valid;

  // Results of the scan: the lowest matching busy slot and the lowest free
  // slot. Both are kept over the whole table, so a duplicate key sitting
  // beyond a free slot is still found.
  logic            match_found;
  kst_pkg::slot_t  match_idx;
  kst_pkg::value_t match_value;
  logic            free_found;
  kst_pkg::slot_t  free_idx;

  kst_pkg::kst_wr_t wr;
  kst_pkg::kst_rd_t rd;

  // Decision made in the finish cycle.
  kst_pkg::status_t res_status;
  kst_pkg::value_t  res_value;
  kst_pkg::slot_t   res_slot;

  logic accept;
  logic hit;

  localparam kst_pkg::slot_t LAST_SLOT = kst_pkg::SLOT_BITS'(kst_pkg::TABLE_SLOTS - 1);

  assign accept = start && !busy;
  assign hit    = cmp_valid && rd.busy && (rd.key == key);

  kst_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (scan_idx),
    .rd     (rd)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, busy flag, store write and the decision taken at the end of the scan.
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    res_status = kst_pkg::ST_NFOUND;
    res_value  = '0;
    res_slot   = '0;
    wr         = '0;
    wr.key     = key;
    wr.value   = value;

    unique case (state)
      kst_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = kst_pkg::S_SCAN;
        end
      end
      kst_pkg::S_SCAN: begin
        if (scan_idx == LAST_SLOT) begin
          state_next = kst_pkg::S_DRAIN;
        end
      end
      kst_pkg::S_DRAIN: begin
        state_next = kst_pkg::S_FINISH;
      end
      kst_pkg::S_FINISH: begin
        state_next = kst_pkg::S_IDLE;
        unique case (cmd)
          kst_pkg::CMD_INSERT: begin
            if (match_found) begin
              res_status = kst_pkg::ST_DUP;
            end else if (free_found) begin
              res_status  = kst_pkg::ST_OK;
              res_slot    = free_idx;
              wr.data_en  = 1'b1;
              wr.busy_set = 1'b1;
              wr.idx      = free_idx;
            end else begin
              res_status = kst_pkg::ST_FULL;
            end
          end
          kst_pkg::CMD_REMOVE: begin
            if (match_found) begin
              res_status  = kst_pkg::ST_OK;
              res_slot    = match_idx;
              wr.busy_clr = 1'b1;
              wr.idx      = match_idx;
            end
          end
          kst_pkg::CMD_SEARCH: begin
            if (match_found) begin
              res_status = kst_pkg::ST_OK;
              res_slot   = match_idx;
              res_value  = match_value;
            end
          end
          default: begin
            // The unused command code changes nothing and reports not found.
            res_status = kst_pkg::ST_NFOUND;
          end
        endcase
      end
      default: begin
        state_next = kst_pkg::S_IDLE;
      end
    endcase
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd         <= kst_pkg::cmd_t'(command);
      key         <= lookup_key[kst_pkg::KEY_BITS-1:0];
      value       <= new_value;
      scan_idx    <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (state == kst_pkg::S_SCAN && scan_idx != LAST_SLOT) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
        match_value <= rd.value;
      end
      if (cmp_valid && !rd.busy && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    cmp_idx <= scan_idx;
  end

  // Compare-stage valid and the result strobe are control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cmp_valid <= (state == kst_pkg::S_SCAN);
      done      <= (state == kst_pkg::S_FINISH);
    end
  end

  // Result payload, registered alongside the strobe.
  always_ff @(posedge clk) begin
    if (state == kst_pkg::S_FINISH) begin
      status      <= res_status;
      found_value <= $signed(res_value);
      slot_index  <= kst_pkg::INDEX_BITS'(res_slot);
    end
  end

endmodule

// File: rtl/kst_store.sv
// ----------------------------------------------------------------------------
// kst_store: slot storage
// Key and value memories with one write and one registered read port, and
// the busy flags, which reset clears so that every slot starts free.
// ----------------------------------------------------------------------------
module kst_store (
  input  logic             clk,
  input  logic             rst,
  input  kst_pkg::kst_wr_t wr,
  input  kst_pkg::slot_t   rd_idx,
  output kst_pkg::kst_rd_t rd
);

  kst_pkg::key_t   key_mem   [kst_pkg::TABLE_SLOTS];
  kst_pkg::value_t value_mem [kst_pkg::TABLE_SLOTS];
  logic [kst_pkg::TABLE_SLOTS-1:0] slot_busy;

  // The key and value memories need no reset; only the busy flags and the
  // registered busy read are cleared.
  always_ff @(posedge clk) begin
    if (wr.data_en) begin
      key_mem[wr.idx]   <= wr.key;
      value_mem[wr.idx] <= wr.value;
    end
    rd.key   <= key_mem[rd_idx];
    rd.value <= value_mem[rd_idx];
    if (rst) begin
      slot_busy <= '0;
      rd.busy   <= 1'b0;
    end else begin
      if (wr.busy_set) begin
        slot_busy[wr.idx] <= 1'b1;
      end else if (wr.busy_clr) begin
        slot_busy[wr.idx] <= 1'b0;
      end
      rd.busy <= slot_busy[rd_idx];
    end
  end

endmodule

// File: tb/keyed_slot_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_checker: result checker for the keyed slot table
// Watches the command and result ports, keeps its own copy of the table to
// work out each expected result, and counts every result that disagrees.
// ----------------------------------------------------------------------------
module keyed_slot_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         command,
  input  logic [63:0]        lookup_key,
  input  logic signed [31:0] new_value,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic signed [31:0] found_value,
  input  logic [3:0]         slot_index,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    kst_pkg::status_t               st;
    kst_pkg::value_t                val;
    logic [kst_pkg::INDEX_BITS-1:0] idx;
  } table_reply_t;

  logic            entry_used [kst_pkg::TABLE_SLOTS];
  kst_pkg::key_t   entry_key  [kst_pkg::TABLE_SLOTS];
  kst_pkg::value_t entry_val  [kst_pkg::TABLE_SLOTS];

  table_reply_t awaited_replies[$];
  int           fail_count = 0;
  int           report_count = 0;

  // Applies one command to the shadow table and gives the reply it should
  // produce. The match search covers every busy entry, holes included.
  task automatic apply_command(input logic [1:0] op, input logic [63:0] raw_key,
                               input kst_pkg::value_t data,
                               output table_reply_t reply);
    kst_pkg::key_t k;
    int            hit;
    int            hole;
    k     = raw_key[kst_pkg::KEY_BITS-1:0];
    hit   = -1;
    hole  = -1;
    for (int i = kst_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
      if (entry_used[i] && entry_key[i] == k) hit = i;
      if (!entry_used[i]) hole = i;
    end
    reply.st  = kst_pkg::ST_NFOUND;
    reply.val = '0;
    reply.idx = '0;
    case (op)
      kst_pkg::CMD_INSERT: begin
        if (hit >= 0) begin
          reply.st = kst_pkg::ST_DUP;
        end else if (hole < 0) begin
          reply.st = kst_pkg::ST_FULL;
        end else begin
          entry_used[hole] = 1'b1;
          entry_key[hole]  = k;
          entry_val[hole]  = data;
          reply.st         = kst_pkg::ST_OK;
          reply.idx        = hole[kst_pkg::INDEX_BITS-1:0];
        end
      end
      kst_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          entry_used[hit] = 1'b0;
          reply.st        = kst_pkg::ST_OK;
          reply.idx       = hit[kst_pkg::INDEX_BITS-1:0];
        end
      end
      kst_pkg::CMD_SEARCH: begin
        if (hit >= 0) begin
          reply.st  = kst_pkg::ST_OK;
          reply.val = entry_val[hit];
          reply.idx = hit[kst_pkg::INDEX_BITS-1:0];
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    table_reply_t got;
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < kst_pkg::TABLE_SLOTS; i++) entry_used[i] = 1'b0;
      awaited_replies.delete();
    end else begin
      // The result leaving in this cycle belongs to an earlier transaction,
      // so it is checked before a transaction accepted at the same edge.
      if (done) begin
        got.st  = kst_pkg::status_t'(status);
        got.val = found_value;
        got.idx = slot_index;
        if (awaited_replies.size() == 0) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display("checker: unexpected result status %0d value %0d slot %0d",
                     got.st, $signed(got.val), got.idx);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            fail_count++;
            if (report_count < 10) begin
              report_count++;
              $display("checker: expected status %0d value %0d slot %0d, got %0d %0d %0d",
                       want.st, $signed(want.val), want.idx,
                       got.st, $signed(got.val), got.idx);
            end
          end
        end
      end
      if (start && !busy) begin
        apply_command(command, lookup_key, new_value, want);
        awaited_replies.push_back(want);
      end
    end
    errors  <= fail_count;
    pending <= awaited_replies.size();
  end

endmodule

// File: tb/tb_keyed_slot_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_slot_table: testbench for the keyed slot table
// Drives insert, remove, search and unused-code transactions with random idle
// gaps, first a directed run through the corner cases and then a long random
// run over a small pool of keys, and leaves the checking to a separate checker.
// ----------------------------------------------------------------------------
module tb_keyed_slot_table;

  // The fourth command code does nothing in the table; it has no package name.
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  // Cycles with no accepted transaction and no result before giving up. The
  // limit lies well above one transaction plus the longest idle gap, so this
  // leaves a wide margin.
  localparam int         STALL_LIMIT = 2000;
  localparam int         RANDOM_ITEMS = 1950;
  localparam int         POOL_SIZE   = 24;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         command;
  logic [63:0]        lookup_key;
  logic signed [31:0] new_value;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] found_value;
  logic [3:0]         slot_index;

  int                 fail_total;
  int                 in_flight;
  int                 quiet_cycles;
  logic [63:0]        key_pool [POOL_SIZE];

  keyed_slot_table dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .slot_index  (slot_index)
  );

  keyed_slot_table_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .slot_index  (slot_index),
    .errors      (fail_total),
    .pending     (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog restarts its count whenever a transaction is taken or a
  // result leaves the block; a long silence means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[keyed_slot_table] ERROR");
        $finish;
      end
    end
  end

  // Presents one transaction after a random idle gap and returns at the
  // edge that accepts it. Most gaps are short so that transactions queue up
  // behind a busy block; a few are long so that the block sits idle. During
  // a gap the data ports carry rubbish that must be ignored. Inputs change
  // only at the falling edge, and each signal is assigned once per edge.
  task automatic send_command(input logic [1:0] op, input logic [63:0] k,
                              input logic [31:0] v);
    int roll;
    int gap;
    roll = $urandom_range(99);
    if (roll < 55)      gap = 0;
    else if (roll < 88) gap = $urandom_range(4, 1);
    else if (roll < 96) gap = $urandom_range(25, 5);
    else                gap = $urandom_range(60, 26);
    repeat (gap) begin
      @(negedge clk);
      start      <= 1'b0;
      command    <= $urandom_range(3);
      lookup_key <= {$urandom, $urandom};
      new_value  <= $urandom;
    end
    @(negedge clk);
    start      <= 1'b1;
    command    <= op;
    lookup_key <= k;
    new_value  <= v;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    int          roll;
    int          insert_share;
    int          remove_share;
    logic [1:0]  op;
    logic [63:0] k;

    rst        = 1'b1;
    start      = 1'b0;
    command    = kst_pkg::CMD_INSERT;
    lookup_key = '0;
    new_value  = '0;

    // The pool holds more keys than there are slots so that the table can
    // fill up. Some entries differ from the third key in a single bit, which
    // tests that the comparator looks at every bit of the key.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      if (i < 12) key_pool[i] = {$urandom, $urandom};
      else        key_pool[i] = key_pool[2] ^ (64'd1 << $urandom_range(63));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty table answers not found to everything, and
    // the unused command code changes nothing.
    send_command(kst_pkg::CMD_SEARCH, '0, '0);
    send_command(kst_pkg::CMD_REMOVE, '0, '0);
    send_command(CMD_UNUSED, '1, '1);
    // Extreme keys with extreme values, then a duplicate insert and a search for each key.
    send_command(kst_pkg::CMD_INSERT, '1, 32'h7fff_ffff);
    send_command(kst_pkg::CMD_INSERT, '0, 32'h8000_0000);
    send_command(kst_pkg::CMD_INSERT, '0, 32'h0000_0001);
    send_command(kst_pkg::CMD_SEARCH, '1, '0);
    send_command(kst_pkg::CMD_SEARCH, '0, '1);
    // Free the lowest slot, leaving a hole in front of the busy one. The
    // duplicate check must still find the key sitting behind that hole.
    send_command(kst_pkg::CMD_REMOVE, '1, '0);
    send_command(kst_pkg::CMD_INSERT, '0, 32'h1234_5678);
    // Fill every remaining slot, the hole first.
    for (int i = 1; i < kst_pkg::TABLE_SLOTS; i++) begin
      send_command(kst_pkg::CMD_INSERT, 64'(i), {$urandom});
    end
    // With the table full a duplicate key still reports duplicate rather
    // than full, and a fresh key reports full.
    send_command(kst_pkg::CMD_INSERT, '0, '1);
    send_command(kst_pkg::CMD_INSERT, 64'hdead_beef_0000_0001, '1);

    // Random part. Phases alternate between filling and draining the table
    // so that both the full and the empty table are visited many times.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n / 150) % 2 == 0) begin
        insert_share = 55;
        remove_share = 15;
      end else begin
        insert_share = 20;
        remove_share = 50;
      end
      roll = $urandom_range(99);
      if (roll < insert_share)                     op = kst_pkg::CMD_INSERT;
      else if (roll < insert_share + remove_share) op = kst_pkg::CMD_REMOVE;
      else if (roll < 95)                          op = kst_pkg::CMD_SEARCH;
      else                                         op = CMD_UNUSED;
      if ($urandom_range(99) < 88) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else                         k = {$urandom, $urandom};
      send_command(op, k, $urandom);
    end

    @(negedge clk);
    start <= 1'b0;

    // Wait for every outstanding result, then a little longer than one
    // transaction so that any stray result would still be caught.
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (kst_pkg::TABLE_SLOTS + 8) @(posedge clk);

    if (fail_total == 0) begin
      $display("[keyed_slot_table] OK");
    end else begin
      $display("[keyed_slot_table] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kst_pkg.sv
rtl/kst_store.sv
rtl/keyed_slot_table.sv
tb/keyed_slot_table_checker.sv
tb/tb_keyed_slot_table.sv
